FILE: rtl/ial_pkg.sv
// ial_pkg: shared opcodes, status codes, datapath command codes and the
// controller status bundle for the integer alu with gcd/lcm.
// No dependencies; used by every rtl file of the block.
`default_nettype none

package ial_pkg;

  // default operand width
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // widths of the fixed fields
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STATUS_W = 2;

  // operation codes carried in the input tuser
  localparam logic [KIND_W-1:0] OP_ADD = 3'd0;
  localparam logic [KIND_W-1:0] OP_SUB = 3'd1;
  localparam logic [KIND_W-1:0] OP_MUL = 3'd2;
  localparam logic [KIND_W-1:0] OP_DIV = 3'd3;
  localparam logic [KIND_W-1:0] OP_REM = 3'd4;
  localparam logic [KIND_W-1:0] OP_GCD = 3'd5;
  localparam logic [KIND_W-1:0] OP_LCM = 3'd6;

  // result status codes carried in the output tuser
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIV0  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADOP = 2'd2;

  // commands from the controller to the datapath
  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_LOAD     = 3'd1,
    CMD_MUL_STEP = 3'd2,
    CMD_DIV_STEP = 3'd3,
    CMD_GCD_STEP = 3'd4,
    CMD_LCM_DIV  = 3'd5,
    CMD_LCM_MUL  = 3'd6,
    CMD_FINISH   = 3'd7
  } ial_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;      // latched opcode
    logic              special;   // divide by zero or bad gcd/lcm operand
    logic              cnt_last;  // last iteration of a shift loop
    logic              gcd_eq;    // binary gcd has converged
    logic              out_free;  // output register can take a result
  } ial_stat_t;

endpackage

`default_nettype wire

FILE: rtl/integer_alu_gcd_lcm_core.sv
// integer_alu_gcd_lcm_core: top level of the signed integer alu with gcd/lcm.
// Depends on ial_pkg, ial_ctrl and ial_datapath.
//
// One operation per beat: add, sub, mul, div, rem, gcd, lcm on two signed
// DATA_WIDTH operands, one result beat per input beat, in order. Items are
// worked one at a time by a shared iterative datapath. After the accepting
// edge each item passes a dispatch state, and a finish state loads the
// output register; add, sub, an unused opcode and rejected operands go
// straight from dispatch to finish; mul, div and rem first run the
// shift-add multiplier or the restoring divider, one bit per cycle; gcd
// first runs binary gcd steps until the two values are equal; lcm adds a
// division and a multiplication after that. The output register lets a
// finished result wait while the next beat is taken; a computed result
// waits only while the previous one is still held.
`default_nettype none

module integer_alu_gcd_lcm_core #(
  parameter int unsigned DATA_WIDTH = ial_pkg::DATA_WIDTH_DEF,
  localparam int unsigned S_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned M_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]          s_axis_tdata,  // operand_a, operand_b, zero pad
  input  wire logic [ial_pkg::KIND_W-1:0]    s_axis_tuser,  // kind
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [M_TDATA_W-1:0]               m_axis_tdata,  // value, zero pad
  output logic [ial_pkg::STATUS_W-1:0]       m_axis_tuser   // status
);

  ial_pkg::ial_cmd_t  cmd;
  ial_pkg::ial_stat_t stat;
  logic [DATA_WIDTH-1:0] value;

  // sequencer
  ial_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic units and output register
  ial_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .kind_in    (s_axis_tuser),
    .a_in       (s_axis_tdata[DATA_WIDTH-1:0]),
    .b_in       (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_value  (value),
    .out_status (m_axis_tuser)
  );

  assign m_axis_tdata = M_TDATA_W'(value);

endmodule

`default_nettype wire

FILE: rtl/ial_ctrl.sv
// ial_ctrl: sequencing state machine of the integer alu.
// Depends on ial_pkg for command codes, opcodes and the status bundle.
`default_nettype none

module ial_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ial_pkg::ial_stat_t stat,
  output ial_pkg::ial_cmd_t       cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DISP = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_GCD  = 7'b0010000,
    S_LCMM = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and datapath command
  always_comb begin
    state_next = state;
    cmd        = ial_pkg::CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = ial_pkg::CMD_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.special) begin
          state_next = S_FIN;
        end else if (stat.kind == ial_pkg::OP_MUL) begin
          state_next = S_MUL;
        end else if (stat.kind == ial_pkg::OP_DIV || stat.kind == ial_pkg::OP_REM) begin
          state_next = S_DIV;
        end else if (stat.kind == ial_pkg::OP_GCD || stat.kind == ial_pkg::OP_LCM) begin
          state_next = S_GCD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_MUL: begin
        cmd = ial_pkg::CMD_MUL_STEP;
        if (stat.cnt_last) begin
          state_next = S_FIN;
        end
      end
      S_DIV: begin
        cmd = ial_pkg::CMD_DIV_STEP;
        if (stat.cnt_last) begin
          state_next = (stat.kind == ial_pkg::OP_LCM) ? S_LCMM : S_FIN;
        end
      end
      S_GCD: begin
        if (!stat.gcd_eq) begin
          cmd = ial_pkg::CMD_GCD_STEP;
        end else if (stat.kind == ial_pkg::OP_LCM) begin
          // divide a by the gcd next
          cmd        = ial_pkg::CMD_LCM_DIV;
          state_next = S_DIV;
        end else begin
          state_next = S_FIN;
        end
      end
      S_LCMM: begin
        // multiply the quotient by b
        cmd        = ial_pkg::CMD_LCM_MUL;
        state_next = S_MUL;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd        = ial_pkg::CMD_FINISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/ial_datapath.sv
// ial_datapath: operand registers, shift-add multiplier, restoring divider,
// binary gcd unit and the output register of the integer alu.
// Depends on ial_pkg for command codes, opcodes, status codes and ial_stat_t.
`default_nettype none

module ial_datapath #(
  parameter int unsigned DATA_WIDTH = ial_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ial_pkg::ial_cmd_t              cmd,
  output ial_pkg::ial_stat_t                  stat,
  input  wire logic [ial_pkg::KIND_W-1:0]     kind_in,
  input  wire logic [DATA_WIDTH-1:0]          a_in,
  input  wire logic [DATA_WIDTH-1:0]          b_in,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [DATA_WIDTH-1:0]               out_value,
  output logic [ial_pkg::STATUS_W-1:0]        out_status
);

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH + 1);
  localparam int unsigned K_W   = $clog2(DATA_WIDTH);

  // operand copies and working registers
  logic [ial_pkg::KIND_W-1:0] kind_q;
  logic                       sign_a;
  logic                       sign_b;
  logic                       special;
  logic [DATA_WIDTH-1:0]      a_q;
  logic [DATA_WIDTH-1:0]      b_q;
  logic [DATA_WIDTH-1:0]      x;
  logic [DATA_WIDTH-1:0]      y;
  logic [DATA_WIDTH-1:0]      z;
  logic [CNT_W-1:0]           cnt;
  logic [K_W-1:0]             k;

  // load-time decode
  logic                  is_divrem;
  logic                  is_gcdlcm;
  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;
  logic                  load_special;

  assign is_divrem = (kind_in == ial_pkg::OP_DIV) || (kind_in == ial_pkg::OP_REM);
  assign is_gcdlcm = (kind_in == ial_pkg::OP_GCD) || (kind_in == ial_pkg::OP_LCM);
  assign mag_a = a_in[DATA_WIDTH-1] ? (~a_in) + DATA_WIDTH'(1) : a_in;
  assign mag_b = b_in[DATA_WIDTH-1] ? (~b_in) + DATA_WIDTH'(1) : b_in;
  assign load_special =
      (is_divrem && (b_in == '0)) ||
      (is_gcdlcm && (a_in[DATA_WIDTH-1] || b_in[DATA_WIDTH-1] ||
                     (a_in == '0) || (b_in == '0)));

  // restoring divider trial subtract: x shifts the dividend out and the quotient in
  logic [DATA_WIDTH:0] div_trial;
  logic [DATA_WIDTH:0] div_diff;
  logic                div_ge;

  assign div_trial = {z, x[DATA_WIDTH-1]};
  assign div_diff  = div_trial - {1'b0, y};
  assign div_ge    = !div_diff[DATA_WIDTH];

  // gcd value with the common powers of two restored
  logic [DATA_WIDTH-1:0] gcd_val;
  assign gcd_val = x << k;

  // working register updates
  always_ff @(posedge clk) begin
    unique case (cmd)
      ial_pkg::CMD_LOAD: begin
        kind_q  <= kind_in;
        sign_a  <= a_in[DATA_WIDTH-1];
        sign_b  <= b_in[DATA_WIDTH-1];
        special <= load_special;
        a_q     <= a_in;
        b_q     <= b_in;
        x       <= is_divrem ? mag_a : a_in;
        y       <= is_divrem ? mag_b : b_in;
        z       <= '0;
        cnt     <= CNT_W'(DATA_WIDTH);
        k       <= '0;
      end
      ial_pkg::CMD_MUL_STEP: begin
        if (y[0]) begin
          z <= z + x;
        end
        x   <= {x[DATA_WIDTH-2:0], 1'b0};
        y   <= {1'b0, y[DATA_WIDTH-1:1]};
        cnt <= cnt - CNT_W'(1);
      end
      ial_pkg::CMD_DIV_STEP: begin
        if (div_ge) begin
          z <= div_diff[DATA_WIDTH-1:0];
        end else begin
          z <= div_trial[DATA_WIDTH-1:0];
        end
        x   <= {x[DATA_WIDTH-2:0], div_ge};
        cnt <= cnt - CNT_W'(1);
      end
      ial_pkg::CMD_GCD_STEP: begin
        // one binary gcd step; x and y are known to differ
        priority if (!x[0] && !y[0]) begin
          x <= {1'b0, x[DATA_WIDTH-1:1]};
          y <= {1'b0, y[DATA_WIDTH-1:1]};
          k <= k + K_W'(1);
        end else if (!x[0]) begin
          x <= {1'b0, x[DATA_WIDTH-1:1]};
        end else if (!y[0]) begin
          y <= {1'b0, y[DATA_WIDTH-1:1]};
        end else if (x > y) begin
          x <= (x - y) >> 1;
        end else begin
          y <= (y - x) >> 1;
        end
      end
      ial_pkg::CMD_LCM_DIV: begin
        x   <= a_q;
        y   <= gcd_val;
        z   <= '0;
        cnt <= CNT_W'(DATA_WIDTH);
      end
      ial_pkg::CMD_LCM_MUL: begin
        y   <= b_q;
        z   <= '0;
        cnt <= CNT_W'(DATA_WIDTH);
      end
      ial_pkg::CMD_NONE, ial_pkg::CMD_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // final result select by opcode
  logic [DATA_WIDTH-1:0]        res_value;
  logic [ial_pkg::STATUS_W-1:0] res_status;

  always_comb begin
    res_value  = '0;
    res_status = ial_pkg::ST_OK;
    unique case (kind_q)
      ial_pkg::OP_ADD: res_value = a_q + b_q;
      ial_pkg::OP_SUB: res_value = a_q - b_q;
      ial_pkg::OP_MUL: res_value = z;
      ial_pkg::OP_DIV: begin
        if (special) begin
          res_status = ial_pkg::ST_DIV0;
        end else begin
          res_value = (sign_a ^ sign_b) ? (~x) + DATA_WIDTH'(1) : x;
        end
      end
      ial_pkg::OP_REM: begin
        if (special) begin
          res_status = ial_pkg::ST_DIV0;
        end else begin
          res_value = sign_a ? (~z) + DATA_WIDTH'(1) : z;
        end
      end
      ial_pkg::OP_GCD: begin
        if (special) begin
          res_status = ial_pkg::ST_BADOP;
        end else begin
          res_value = gcd_val;
        end
      end
      ial_pkg::OP_LCM: begin
        if (special) begin
          res_status = ial_pkg::ST_BADOP;
        end else begin
          res_value = z;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == ial_pkg::CMD_FINISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == ial_pkg::CMD_FINISH) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

  // status toward the controller
  assign stat.kind     = kind_q;
  assign stat.special  = special;
  assign stat.cnt_last = (cnt == CNT_W'(1));
  assign stat.gcd_eq   = (x == y);
  assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

FILE: rtl/ial_checker.sv
// ial_checker: port-level checks of integer_alu_gcd_lcm_core, bound to it.
// Depends on ial_pkg for status codes and widths.
`default_nettype none

module ial_checker #(
  parameter int unsigned DATA_WIDTH = ial_pkg::DATA_WIDTH_DEF,
  localparam int unsigned M_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [M_TDATA_W-1:0]        m_axis_tdata,
  input wire logic [ial_pkg::STATUS_W-1:0] m_axis_tuser
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // no result right after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // only defined status codes appear
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ial_pkg::ST_OK ||
                       m_axis_tuser == ial_pkg::ST_DIV0 ||
                       m_axis_tuser == ial_pkg::ST_BADOP))
    else $error("undefined status code");

  // an error status always comes with a zero value
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ial_pkg::ST_OK |-> m_axis_tdata == '0)
    else $error("error result with nonzero value");

  // one item at a time: input is closed the cycle after a beat is taken
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while busy");

endmodule

bind integer_alu_gcd_lcm_core ial_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_ial_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
